// ----- rtl/cmb_pkg.sv -----
// Package for the clipped mask blit block: screen geometry, field widths,
// register indexes and the stage payload type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmb_pkg;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 200;
   localparam int MAX_SRC_SIZE  = 1024;

   localparam int PIXEL_W = 8;
   localparam int COUNT_W = 10;
   localparam int SIZE_W  = 11;
   localparam int POS_W   = 12;
   localparam int ADDR_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int RSP_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FILL_COLOUR = 3'd4;

   typedef struct packed {
      logic [PIXEL_W-1:0]    pixel;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                  last;
   } stage_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] result;
      if (size == '0) begin
         result = SIZE_W'(1);
      end else if (size > SIZE_W'(MAX_SRC_SIZE)) begin
         result = SIZE_W'(MAX_SRC_SIZE);
      end else begin
         result = size;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/clipped_mask_blit_top.sv -----
// Top level of the clipped mask blit: pixel counters, input stage and result stage.
// Depends on cmb_pkg for geometry, widths, register indexes and the stage type.
//
// Usage: source pixels of a rectangle enter on the req_ channel, one beat per
// pixel in row-major order. Every accepted beat yields exactly one beat on
// the rsp_ channel carrying write enable, frame buffer address and data, with
// rsp_tlast marking the final pixel of the rectangle. Transparent and
// off-screen pixels come out with write enable low and zero address and data.
// The user must write registers on the csr_ channel only while the block is idle;
// the block does not enforce this. The csr_ channel is always ready.
// An accepted request beat passes the input stage and result registers to its response beat.
// Throughput is one pixel per cycle through the two-register pipeline while rsp_tready holds.
// Reset clears the counters and both stage valid bits and restores the
// register defaults (1x1 rectangle at the origin, fill color zero). When the
// receiver stalls, the result register holds its beat and the input stage
// keeps accepting until it is full too; no beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module clipped_mask_blit_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [cmb_pkg::PIXEL_W-1:0]         req_tdata,  // [7:0] src_pixel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [cmb_pkg::RSP_DATA_W-1:0]           rsp_tdata,  // [0] write_enable,
                                                                // [16:1] write_address,
                                                                // [24:17] write_data,
                                                                // [31:25] zero
   output logic                                     rsp_tlast,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cmb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [cmb_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic [cmb_pkg::SIZE_W-1:0]         src_width_ff;
   logic [cmb_pkg::SIZE_W-1:0]         src_height_ff;
   logic signed [cmb_pkg::SIZE_W-1:0]  dest_x_ff;
   logic signed [cmb_pkg::SIZE_W-1:0]  dest_y_ff;
   logic [cmb_pkg::PIXEL_W-1:0]        fill_colour_ff;

   logic [cmb_pkg::COUNT_W-1:0]        column_ff;
   logic [cmb_pkg::COUNT_W-1:0]        column_in;
   logic [cmb_pkg::COUNT_W-1:0]        row_ff;
   logic [cmb_pkg::COUNT_W-1:0]        row_in;

   logic                               s1_valid_ff;
   cmb_pkg::stage_type                 s1_ff;
   cmb_pkg::stage_type                 s1_in;
   logic                               s2_valid_ff;
   logic [cmb_pkg::RSP_DATA_W-1:0]     s2_data_ff;
   logic [cmb_pkg::RSP_DATA_W-1:0]     s2_data_in;
   logic                               s2_last_ff;

   logic                               req_fire;
   logic                               s2_ready;
   logic                               s1_move;
   logic [cmb_pkg::SIZE_W-1:0]         width_eff;
   logic [cmb_pkg::SIZE_W-1:0]         height_eff;
   logic                               row_end;
   logic                               rect_last;

   logic                               on_screen;
   logic                               write_enable;
   logic [cmb_pkg::ADDR_W-1:0]         write_address;
   logic [cmb_pkg::PIXEL_W-1:0]        write_data;
   logic [cmb_pkg::SIZE_W-1:0]         col_u;
   logic [cmb_pkg::SIZE_W-1:0]         row_u;

   assign csr_ready  = 1'b1;
   assign s2_ready   = !s2_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_move    = s1_valid_ff && s2_ready;

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = s2_data_ff;
   assign rsp_tlast  = s2_last_ff;

   always_comb begin
      width_eff  = cmb_pkg::eff_size(src_width_ff);
      height_eff = cmb_pkg::eff_size(src_height_ff);
      row_end    = ({1'b0, column_ff} + cmb_pkg::SIZE_W'(1)) >= width_eff;
      rect_last  = row_end && (({1'b0, row_ff} + cmb_pkg::SIZE_W'(1)) >= height_eff);

      if (row_end) begin
         column_in = '0;
         row_in    = rect_last ? '0 : row_ff + cmb_pkg::COUNT_W'(1);
      end else begin
         column_in = column_ff + cmb_pkg::COUNT_W'(1);
         row_in    = row_ff;
      end

      s1_in.pixel = req_tdata;
      s1_in.pos_x = {dest_x_ff[cmb_pkg::SIZE_W-1], dest_x_ff}
                    + $signed({2'b00, column_ff});
      s1_in.pos_y = {dest_y_ff[cmb_pkg::SIZE_W-1], dest_y_ff}
                    + $signed({2'b00, row_ff});
      s1_in.last  = rect_last;
   end

   always_comb begin
      on_screen = !s1_ff.pos_x[cmb_pkg::POS_W-1] && !s1_ff.pos_y[cmb_pkg::POS_W-1]
                  && (s1_ff.pos_x < cmb_pkg::POS_W'(cmb_pkg::SCREEN_WIDTH))
                  && (s1_ff.pos_y < cmb_pkg::POS_W'(cmb_pkg::SCREEN_HEIGHT));
      write_enable = (s1_ff.pixel != '0) && on_screen;
      col_u = s1_ff.pos_x[cmb_pkg::SIZE_W-1:0];
      row_u = s1_ff.pos_y[cmb_pkg::SIZE_W-1:0];
      write_address = '0;
      write_data    = '0;
      if (write_enable) begin
         write_address = cmb_pkg::ADDR_W'(32'(row_u) * 32'(cmb_pkg::SCREEN_WIDTH)
                                          + 32'(col_u));
         write_data    = (s1_ff.pixel == cmb_pkg::PIXEL_W'(1)) ? '0 : fill_colour_ff;
      end
      s2_data_in = cmb_pkg::RSP_DATA_W'({write_data, write_address, write_enable});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= cmb_pkg::SIZE_W'(1);
         src_height_ff  <= cmb_pkg::SIZE_W'(1);
         dest_x_ff      <= '0;
         dest_y_ff      <= '0;
         fill_colour_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cmb_pkg::REG_SRC_WIDTH: begin
               src_width_ff <= csr_data;
            end
            cmb_pkg::REG_SRC_HEIGHT: begin
               src_height_ff <= csr_data;
            end
            cmb_pkg::REG_DEST_X: begin
               dest_x_ff <= $signed(csr_data);
            end
            cmb_pkg::REG_DEST_Y: begin
               dest_y_ff <= $signed(csr_data);
            end
            cmb_pkg::REG_FILL_COLOUR: begin
               fill_colour_ff <= csr_data[cmb_pkg::PIXEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            column_ff <= column_in;
            row_ff    <= row_in;
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         s2_data_ff <= s2_data_in;
         s2_last_ff <= s1_ff.last;
      end
   end

endmodule

`default_nettype wire
